// ===== rtl/core/gwwlb_pkg.sv =====
// Shared types, constants and helpers of the greedy word-wrap line breaker.
// Used by every module in rtl/core; no dependencies.
`default_nettype none
package gwwlb_pkg;

  localparam int X_W         = 24;   // pen and row positions, sixteenths of a pixel
  localparam int ADV_W       = 12;   // glyph advance width
  localparam int WRAP_W      = 25;   // signed wrap width register
  localparam int LINE_IDX_W  = 13;   // character index on the result channel
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 25;
  localparam int MAX_CHARS_DEF = 4096;

  localparam int OUTQ_DEPTH  = 4;
  localparam int OUTQ_PTR_W  = 2;
  localparam int OUTQ_CNT_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_WIDTH  = 1'b0,
    CFG_SPACE_WIDTH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_CHAR  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic [LINE_IDX_W-1:0] line_start;
    logic [LINE_IDX_W-1:0] line_end;
    logic [X_W-1:0]        line_width;
    logic                  last_of_run;
  } line_t;

  // lines raised by one item, first in l0
  typedef struct packed {
    logic [1:0] n;
    line_t      l0;
    line_t      l1;
  } lines_t;

  function automatic logic [X_W-1:0] sat_add(input logic [X_W-1:0] a,
                                             input logic [ADV_W-1:0] b);
    logic [X_W:0] s;
    s = {1'b0, a} + {{(X_W+1-ADV_W){1'b0}}, b};
    return s[X_W] ? {X_W{1'b1}} : s[X_W-1:0];
  endfunction

  function automatic logic [X_W-1:0] width_between(input logic [X_W-1:0] from_x,
                                                   input logic [X_W-1:0] to_x);
    return (to_x <= from_x) ? '0 : (to_x - from_x);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gwwlb_core.sv =====
// Row tracking state and break decision of the line breaker.
// Depends on gwwlb_pkg; produces up to two lines per accepted item.
`default_nettype none
module gwwlb_core #(
  parameter int MAX_CHARS = gwwlb_pkg::MAX_CHARS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_fire,
  input  wire                            operation,
  input  wire                            is_space,
  input  wire  [gwwlb_pkg::ADV_W-1:0]    advance_width,
  input  wire  [gwwlb_pkg::WRAP_W-1:0]   wrap_width,
  input  wire  [gwwlb_pkg::ADV_W-1:0]    space_width,
  output gwwlb_pkg::lines_t              lines
);
  import gwwlb_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CHARS + 1);
  localparam int WIDE_W = (IDX_W > LINE_IDX_W) ? IDX_W : LINE_IDX_W;

  logic [IDX_W-1:0] char_count_r,      char_count_nxt;
  logic [X_W-1:0]   pen_x_r,           pen_x_nxt;
  logic [IDX_W-1:0] row_start_index_r, row_start_index_nxt;
  logic [X_W-1:0]   row_start_x_r,     row_start_x_nxt;
  logic             break_valid_r,     break_valid_nxt;
  logic [IDX_W-1:0] break_index_r,     break_index_nxt;
  logic [X_W-1:0]   break_x_r,         break_x_nxt;

  logic             enabled;
  logic             row_gt;
  logic [X_W+1:0]   row_diff;
  logic [X_W+1:0]   wrap_ext;
  logic [X_W-1:0]   break_next_x;

  function automatic line_t make_line(input logic [IDX_W-1:0] s,
                                      input logic [IDX_W-1:0] e,
                                      input logic [X_W-1:0]   from_x,
                                      input logic [X_W-1:0]   to_x,
                                      input logic             last);
    logic [WIDE_W-1:0] s_w;
    logic [WIDE_W-1:0] e_w;
    line_t             l;
    s_w           = WIDE_W'(s);
    e_w           = WIDE_W'(e);
    l.line_start  = s_w[LINE_IDX_W-1:0];
    l.line_end    = e_w[LINE_IDX_W-1:0];
    l.line_width  = width_between(from_x, to_x);
    l.last_of_run = last;
    return l;
  endfunction

  assign enabled      = !wrap_width[WRAP_W-1];
  assign row_diff     = {2'b00, pen_x_r} - {2'b00, row_start_x_r};
  assign wrap_ext     = {{(X_W+2-WRAP_W){wrap_width[WRAP_W-1]}}, wrap_width};
  assign row_gt       = $signed(row_diff) > $signed(wrap_ext);
  assign break_next_x = sat_add(break_x_r, space_width);

  always_comb begin
    char_count_nxt      = char_count_r;
    pen_x_nxt           = pen_x_r;
    row_start_index_nxt = row_start_index_r;
    row_start_x_nxt     = row_start_x_r;
    break_valid_nxt     = break_valid_r;
    break_index_nxt     = break_index_r;
    break_x_nxt         = break_x_r;
    lines               = '0;

    if (operation == OP_FLUSH) begin
      if (enabled && (row_start_index_r != char_count_r)) begin
        if (row_gt && break_valid_r) begin
          lines.n  = 2'd2;
          lines.l0 = make_line(row_start_index_r, break_index_r, row_start_x_r,
                               break_x_r, 1'b0);
          lines.l1 = make_line(break_index_r + 1'b1, char_count_r, break_next_x,
                               pen_x_r, 1'b1);
        end else begin
          lines.n  = 2'd1;
          lines.l0 = make_line(row_start_index_r, char_count_r, row_start_x_r,
                               pen_x_r, 1'b1);
        end
      end
      char_count_nxt      = '0;
      pen_x_nxt           = '0;
      row_start_index_nxt = '0;
      row_start_x_nxt     = '0;
      break_valid_nxt     = 1'b0;
      break_index_nxt     = '0;
      break_x_nxt         = '0;
    end else if (char_count_r < IDX_W'(MAX_CHARS)) begin
      if (enabled && is_space) begin
        if (row_gt) begin
          lines.n = 2'd1;
          if (break_valid_r) begin
            // close the row at the previous space, this space becomes the break
            lines.l0 = make_line(row_start_index_r, break_index_r, row_start_x_r,
                                 break_x_r, 1'b1);
            row_start_index_nxt = break_index_r + 1'b1;
            row_start_x_nxt     = break_next_x;
            break_index_nxt     = char_count_r;
            break_x_nxt         = pen_x_r;
          end else begin
            lines.l0 = make_line(row_start_index_r, char_count_r, row_start_x_r,
                                 pen_x_r, 1'b1);
            row_start_index_nxt = char_count_r + 1'b1;
            row_start_x_nxt     = sat_add(pen_x_r, space_width);
          end
        end else begin
          break_valid_nxt = 1'b1;
          break_index_nxt = char_count_r;
          break_x_nxt     = pen_x_r;
        end
      end
      pen_x_nxt      = sat_add(pen_x_r, advance_width);
      char_count_nxt = char_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r      <= '0;
      pen_x_r           <= '0;
      row_start_index_r <= '0;
      row_start_x_r     <= '0;
      break_valid_r     <= 1'b0;
      break_index_r     <= '0;
      break_x_r         <= '0;
    end else if (in_fire) begin
      char_count_r      <= char_count_nxt;
      pen_x_r           <= pen_x_nxt;
      row_start_index_r <= row_start_index_nxt;
      row_start_x_r     <= row_start_x_nxt;
      break_valid_r     <= break_valid_nxt;
      break_index_r     <= break_index_nxt;
      break_x_r         <= break_x_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gwwlb_outq.sv =====
// Result queue of the line breaker: takes up to two lines a cycle, gives one
// while out_ready is high. Depends on gwwlb_pkg.
`default_nettype none
module gwwlb_outq (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           push,
  input  wire gwwlb_pkg::lines_t        lines,
  output logic                          space_ok,
  output logic                          out_valid,
  input  wire                           out_ready,
  output gwwlb_pkg::line_t              out_line,
  output logic [gwwlb_pkg::OUTQ_CNT_W-1:0] count
);
  import gwwlb_pkg::*;

  line_t                 mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CNT_W-1:0] count_r,  count_nxt;
  logic [1:0]            push_n;
  logic                  pop;
  logic [OUTQ_PTR_W-1:0] wr_ptr_p1;

  assign push_n    = push ? lines.n : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign out_valid = (count_r != '0);
  assign out_line  = mem_r[rd_ptr_r];
  assign space_ok  = (count_r <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OUTQ_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + OUTQ_PTR_W'(pop);
    count_nxt  = count_r + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= lines.l0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= lines.l1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/greedy_word_wrap_line_breaker.sv =====
// Greedy word-wrap line breaker, top level. Uses gwwlb_pkg, gwwlb_core, gwwlb_outq.
// Throughput: one item per cycle; in_ready stays high while at most two lines
// wait in the four-entry result queue (it drops once three or four wait).
// Raised lines are registered in the result queue and leave on out_* in order.
// Reset (rst_n low at a clock edge): row state, config registers and queue cleared.
`default_nettype none
module greedy_word_wrap_line_breaker #(
  parameter int MAX_CHARS = gwwlb_pkg::MAX_CHARS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [gwwlb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gwwlb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_operation,
  input  wire                                in_is_space,
  input  wire  [gwwlb_pkg::ADV_W-1:0]        in_advance_width,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [gwwlb_pkg::LINE_IDX_W-1:0]   out_line_start,
  output logic [gwwlb_pkg::LINE_IDX_W-1:0]   out_line_end,
  output logic [gwwlb_pkg::X_W-1:0]          out_line_width,
  output logic                               out_last_of_run
);
  import gwwlb_pkg::*;

  logic [WRAP_W-1:0]     wrap_width_r;
  logic [ADV_W-1:0]      space_width_r;
  logic                  in_fire;
  logic                  space_ok;
  lines_t                lines;
  line_t                 out_line;
  logic [OUTQ_CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_width_r  <= '0;
      space_width_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WRAP_WIDTH:  wrap_width_r  <= cfg_wdata[WRAP_W-1:0];
        CFG_SPACE_WIDTH: space_width_r <= cfg_wdata[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;

  gwwlb_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .operation     (in_operation),
    .is_space      (in_is_space),
    .advance_width (in_advance_width),
    .wrap_width    (wrap_width_r),
    .space_width   (space_width_r),
    .lines         (lines)
  );

  gwwlb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .lines     (lines),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_line  (out_line),
    .count     (q_count)
  );

  assign out_line_start  = out_line.line_start;
  assign out_line_end    = out_line.line_end;
  assign out_line_width  = out_line.line_width;
  assign out_last_of_run = out_line.last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overfilled");

  a_two_lines_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && lines.n == 2'd2) |-> (in_operation == OP_FLUSH))
    else $error("two lines raised by a character item");

  a_silent_when_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && wrap_width_r[WRAP_W-1]) |-> (lines.n == 2'd0))
    else $error("line raised with negative wrap width");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && lines.n != 2'd0) |=> (q_count != '0))
    else $error("pushed line missing from queue");

endmodule
`default_nettype wire
